@@ sv/trpb_pkg.sv @@
package trpb_pkg;

    // Source of a received byte
    localparam logic SRC_SCREEN = 1'b0;
    localparam logic SRC_HOST   = 1'b1;

    // Destination of a transmitted byte
    localparam logic [1:0] DEST_NONE   = 2'd0;
    localparam logic [1:0] DEST_HOST   = 2'd1;
    localparam logic [1:0] DEST_SCREEN = 2'd2;

    // Configuration register indexes
    localparam logic CFG_SCREEN_TYPE = 1'b0;
    localparam logic CFG_GOOD_LIMIT  = 1'b1;
    localparam logic [7:0] GOOD_LIMIT_RESET = 8'd128;

    // Screen protocol bytes
    localparam logic [7:0] BYTE_REPORT_OPEN  = 8'hFE;
    localparam logic [7:0] BYTE_REPORT_CLOSE = 8'hFF;
    localparam logic [7:0] BYTE_STATUS       = 8'hF5;
    localparam logic [7:0] BYTE_SCREEN_ACK   = 8'h3D;
    localparam logic [7:0] BYTE_PARAMS_OPEN  = 8'hF4;

    // Host requests
    localparam logic [7:0] REQ_REPORT = 8'h46;
    localparam logic [7:0] REQ_PARAMS = 8'h37;

    // Screen parameters per screen type
    localparam logic [7:0] CRT_P1 = 8'h77;
    localparam logic [7:0] CRT_P2 = 8'h5F;
    localparam logic [7:0] LCD_P1 = 8'h71;
    localparam logic [7:0] LCD_P2 = 8'h59;

    // Corner window of a touch report
    localparam logic [7:0] CORNER_V_MIN  = 8'h5A;
    localparam logic [7:0] CORNER_H_LOW  = 8'h06;
    localparam logic [7:0] CORNER_H_HIGH = 8'h72;
    localparam logic [2:0] CORNER_TARGET = 3'd3;

    localparam logic [8:0] IDLE_MAX = 9'd511;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    typedef enum logic [1:0] {
        CMD_EMPTY  = 2'd0,
        CMD_REPORT = 2'd1,
        CMD_STATUS = 2'd2,
        CMD_PARAM  = 2'd3
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] coord_h;
        logic [7:0] coord_v;
        logic       screen_type;
        logic       lock;
        logic       cam;
        logic       seen;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

@@ sv/touch_report_protocol_bridge.sv @@
// Channel   Dir  tdata (low bit up)                          tuser       tlast
// s_        in   data_byte[7:0]                              func        -
// m_        out  out_byte[7:0], lock_request, cam_mode,      dest[1:0]   last
//                screen_seen, zero fill
// cfg_      in   cfg_addr 0 screen_type, 1 good_limit; cfg_wdata[7:0]
//
// One transaction in per cycle while the command queue has room; results leave one
// per cycle from the output register while m_tready is high; a host request makes 2,
// 4 or 5 results (1 if locked), other transactions 1. The result side sets the rate.
// Reset is synchronous, active low, and leaves the block ready on the next cycle.
// A stalled m_ side fills the four-entry command queue and then drops s_tready.
module touch_report_protocol_bridge #(
    parameter int REPORT_BUF = 128
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte[7:0]
    input  logic        s_tuser,   // func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // out_byte[7:0], lock_request, cam_mode, screen_seen
    output logic [1:0]  m_tuser,   // dest[1:0]
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [7:0]  cfg_wdata
);

    trpb_pkg::cmd_t          push_cmd;
    trpb_pkg::cmd_t          head_cmd;
    trpb_pkg::queue_status_t q_status;
    logic                    accept;
    logic                    pop;

    assign s_tready = !q_status.full;
    assign accept   = s_tvalid && s_tready;

    trpb_front #(
        .REPORT_BUF(REPORT_BUF)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .take      (accept),
        .func      (s_tuser),
        .data_byte (s_tdata),
        .cmd       (push_cmd)
    );

    trpb_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (accept),
        .wr_cmd  (push_cmd),
        .pop     (pop),
        .rd_cmd  (head_cmd),
        .status  (q_status)
    );

    trpb_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (head_cmd),
        .cmd_valid (!q_status.empty),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // An empty result is always the single, last one and carries no byte
    a_empty_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == trpb_pkg::DEST_NONE |-> m_tlast && m_tdata[7:0] == 8'h00)
        else $error("empty result not last or carries a byte");

    // The screen only ever gets the acknowledge byte, and never as the last result
    a_screen_ack: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == trpb_pkg::DEST_SCREEN |->
            !m_tlast && m_tdata[7:0] == trpb_pkg::BYTE_SCREEN_ACK)
        else $error("bad byte to screen");

    // Every host reply closes with the end byte
    a_host_close: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast && m_tuser == trpb_pkg::DEST_HOST |->
            m_tdata[7:0] == trpb_pkg::BYTE_REPORT_CLOSE)
        else $error("host reply not closed");

    // Nothing is popped from an empty queue
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !q_status.empty)
        else $error("command queue underflow");

endmodule

@@ sv/trpb_front.sv @@
module trpb_front #(
    parameter int REPORT_BUF = 128
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic              cfg_addr,
    input  logic [7:0]        cfg_wdata,
    input  logic              take,
    input  logic              func,
    input  logic [7:0]        data_byte,
    output trpb_pkg::cmd_t    cmd
);

    localparam int FILL_W = $clog2(REPORT_BUF);

    logic              screen_type_reg;
    logic [7:0]        good_limit_reg;

    logic              in_report_reg, in_report_next;
    logic              caught_reg, caught_next;
    logic              seen_reg, seen_next;
    logic              cam_reg, cam_next;
    logic              hung_reg, hung_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [7:0]        coord_h_reg, coord_h_next;
    logic [7:0]        coord_v_reg, coord_v_next;
    logic [8:0]        idle_reg, idle_next;
    logic [1:0]        hits_reg, hits_next;
    logic              completed;
    logic              corner_hit;
    logic [2:0]        hits_sum;
    trpb_pkg::cmd_kind_t kind;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            screen_type_reg <= 1'b0;
            good_limit_reg  <= trpb_pkg::GOOD_LIMIT_RESET;
        end else if (cfg_we) begin
            case (cfg_addr)
                trpb_pkg::CFG_SCREEN_TYPE: screen_type_reg <= cfg_wdata[0];
                trpb_pkg::CFG_GOOD_LIMIT:  good_limit_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Classify the byte and work out the next protocol state
    always_comb begin
        in_report_next = in_report_reg;
        caught_next    = caught_reg;
        seen_next      = seen_reg;
        cam_next       = cam_reg;
        hung_next      = hung_reg;
        fill_next      = fill_reg;
        coord_h_next   = coord_h_reg;
        coord_v_next   = coord_v_reg;
        idle_next      = idle_reg;
        hits_next      = hits_reg;
        completed      = 1'b0;
        corner_hit     = 1'b0;
        hits_sum       = {1'b0, hits_reg};
        kind           = trpb_pkg::CMD_EMPTY;

        if (!hung_reg) begin
            if (func == trpb_pkg::SRC_SCREEN) begin
                if (cam_reg) begin
                    hung_next = 1'b1;
                end else begin
                    if (idle_reg != trpb_pkg::IDLE_MAX) begin
                        idle_next = idle_reg + 9'd1;
                    end
                    // Buffer report bytes, keep the two coordinates
                    if (in_report_reg) begin
                        if (fill_reg == '0) begin
                            coord_h_next = data_byte;
                        end else if (fill_reg == FILL_W'(1)) begin
                            coord_v_next = data_byte;
                        end
                        fill_next = fill_reg + FILL_W'(1);
                        if (data_byte == trpb_pkg::BYTE_REPORT_CLOSE) begin
                            caught_next    = 1'b1;
                            in_report_next = 1'b0;
                            completed      = 1'b1;
                        end
                    end
                    if (data_byte == trpb_pkg::BYTE_REPORT_OPEN && !caught_next) begin
                        in_report_next = 1'b1;
                        seen_next      = 1'b1;
                        fill_next      = '0;
                    end
                    if (data_byte == trpb_pkg::BYTE_STATUS) begin
                        seen_next = 1'b1;
                    end
                    // Abort on buffer overflow
                    if (fill_next > FILL_W'(REPORT_BUF - 2)) begin
                        fill_next      = '0;
                        in_report_next = 1'b0;
                        caught_next    = 1'b0;
                    end
                    if (idle_next > {1'b0, good_limit_reg}) begin
                        hung_next = 1'b1;
                    end else if (completed && caught_next) begin
                        // Count corner touches, switch to camera mode at three
                        corner_hit = (coord_v_next >= trpb_pkg::CORNER_V_MIN) &&
                                     ((coord_h_next <= trpb_pkg::CORNER_H_LOW) ||
                                      (coord_h_next >= trpb_pkg::CORNER_H_HIGH));
                        hits_sum = {1'b0, hits_reg} + {2'b00, corner_hit};
                        if (hits_sum >= trpb_pkg::CORNER_TARGET) begin
                            cam_next    = 1'b1;
                            hits_next   = 2'd0;
                            caught_next = 1'b0;
                        end else begin
                            hits_next = hits_sum[1:0];
                        end
                    end
                end
            end else if (data_byte == trpb_pkg::REQ_REPORT) begin
                idle_next = '0;
                if (caught_reg) begin
                    kind        = trpb_pkg::CMD_REPORT;
                    caught_next = 1'b0;
                    fill_next   = '0;
                end else begin
                    kind = trpb_pkg::CMD_STATUS;
                end
            end else if (data_byte == trpb_pkg::REQ_PARAMS) begin
                idle_next = '0;
                kind      = trpb_pkg::CMD_PARAM;
            end
        end
    end

    // Command for the back end, flags as they stand after this byte
    always_comb begin
        cmd.kind        = kind;
        cmd.coord_h     = coord_h_reg;
        cmd.coord_v     = coord_v_reg;
        cmd.screen_type = screen_type_reg;
        cmd.lock        = hung_next;
        cmd.cam         = cam_next;
        cmd.seen        = seen_next;
    end

    // Advance protocol state on each accepted transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_report_reg <= 1'b0;
            caught_reg    <= 1'b0;
            seen_reg      <= 1'b0;
            cam_reg       <= 1'b0;
            hung_reg      <= 1'b0;
            fill_reg      <= '0;
            coord_h_reg   <= '0;
            coord_v_reg   <= '0;
            idle_reg      <= '0;
            hits_reg      <= '0;
        end else if (take) begin
            in_report_reg <= in_report_next;
            caught_reg    <= caught_next;
            seen_reg      <= seen_next;
            cam_reg       <= cam_next;
            hung_reg      <= hung_next;
            fill_reg      <= fill_next;
            coord_h_reg   <= coord_h_next;
            coord_v_reg   <= coord_v_next;
            idle_reg      <= idle_next;
            hits_reg      <= hits_next;
        end
    end

endmodule

@@ sv/trpb_fifo.sv @@
module trpb_fifo (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    push,
    input  trpb_pkg::cmd_t          wr_cmd,
    input  logic                    pop,
    output trpb_pkg::cmd_t          rd_cmd,
    output trpb_pkg::queue_status_t status
);

    trpb_pkg::cmd_t                 slot_reg [trpb_pkg::QUEUE_DEPTH];
    logic [trpb_pkg::QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [trpb_pkg::QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [trpb_pkg::QCNT_W-1:0]    count_reg, count_next;

    // Store commands
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

    assign rd_cmd       = slot_reg[rd_ptr_reg];
    assign status.full  = (count_reg == trpb_pkg::QCNT_W'(trpb_pkg::QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);

    // Move pointers and occupancy
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + trpb_pkg::QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + trpb_pkg::QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + trpb_pkg::QCNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - trpb_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ sv/trpb_back.sv @@
module trpb_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  trpb_pkg::cmd_t cmd,
    input  logic           cmd_valid,
    output logic           pop,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [15:0]    m_tdata,
    output logic [1:0]     m_tuser,
    output logic           m_tlast
);

    logic [2:0]  step_reg, step_next;
    logic        valid_reg, valid_next;
    logic [7:0]  byte_reg;
    logic [1:0]  dest_reg;
    logic        last_reg, lock_reg, cam_reg, seen_reg;
    logic        load;
    logic [7:0]  cur_byte;
    logic [1:0]  cur_dest;
    logic        cur_last;

    // Pick the byte for the current step of the command
    always_comb begin
        cur_byte = 8'h00;
        cur_dest = trpb_pkg::DEST_HOST;
        cur_last = 1'b0;
        case (cmd.kind)
            trpb_pkg::CMD_REPORT: begin
                case (step_reg)
                    3'd0:    cur_byte = trpb_pkg::BYTE_REPORT_OPEN;
                    3'd1:    cur_byte = cmd.coord_h;
                    3'd2:    cur_byte = cmd.coord_v;
                    default: begin
                        cur_byte = trpb_pkg::BYTE_REPORT_CLOSE;
                        cur_last = 1'b1;
                    end
                endcase
            end
            trpb_pkg::CMD_STATUS: begin
                if (step_reg == 3'd0) begin
                    cur_byte = trpb_pkg::BYTE_STATUS;
                end else begin
                    cur_byte = trpb_pkg::BYTE_REPORT_CLOSE;
                    cur_last = 1'b1;
                end
            end
            trpb_pkg::CMD_PARAM: begin
                case (step_reg)
                    3'd0: begin
                        cur_byte = trpb_pkg::BYTE_SCREEN_ACK;
                        cur_dest = trpb_pkg::DEST_SCREEN;
                    end
                    3'd1:    cur_byte = trpb_pkg::BYTE_PARAMS_OPEN;
                    3'd2:    cur_byte = cmd.screen_type ? trpb_pkg::LCD_P1 : trpb_pkg::CRT_P1;
                    3'd3:    cur_byte = cmd.screen_type ? trpb_pkg::LCD_P2 : trpb_pkg::CRT_P2;
                    default: begin
                        cur_byte = trpb_pkg::BYTE_REPORT_CLOSE;
                        cur_last = 1'b1;
                    end
                endcase
            end
            default: begin
                cur_dest = trpb_pkg::DEST_NONE;
                cur_last = 1'b1;
            end
        endcase
    end

    // Load the output register whenever it is free or being drained
    assign load = !valid_reg || m_tready;
    assign pop  = load && cmd_valid && cur_last;

    always_comb begin
        step_next  = step_reg;
        valid_next = valid_reg;
        if (load) begin
            valid_next = cmd_valid;
            if (cmd_valid) begin
                step_next = cur_last ? 3'd0 : step_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg  <= '0;
            valid_reg <= 1'b0;
        end else begin
            step_reg  <= step_next;
            valid_reg <= valid_next;
        end
    end

    // Hold the result payload
    always_ff @(posedge aclk) begin
        if (load && cmd_valid) begin
            byte_reg <= cur_byte;
            dest_reg <= cur_dest;
            last_reg <= cur_last;
            lock_reg <= cmd.lock;
            cam_reg  <= cmd.cam;
            seen_reg <= cmd.seen;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {5'b00000, seen_reg, cam_reg, lock_reg, byte_reg};
    assign m_tuser  = dest_reg;
    assign m_tlast  = last_reg;

endmodule
